// ----- src/url_query_value_locator_top_macros.svh -----
// ----------------------------------------------------------------------------
// URL query value locator assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef URL_QUERY_VALUE_LOCATOR_TOP_MACROS_SVH
`define URL_QUERY_VALUE_LOCATOR_TOP_MACROS_SVH

// Same-cycle implication
`define UQVL_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define UQVL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/uqvl_pkg.sv -----
// ----------------------------------------------------------------------------
// URL query value locator package
// Field widths, character codes, register indexes and the key matcher control.
// ----------------------------------------------------------------------------
package uqvl_pkg;

    // Byte and field widths
    localparam int BYTE_W         = 8;
    localparam int VSTART_W       = 12;
    localparam int VLEN_W         = 13;
    localparam logic [VSTART_W-1:0] VSTART_MAX = '1;

    // Key file shape
    localparam int KEY_REGS       = 4;
    localparam int KEY_TEXT_W     = 64;
    localparam int KEY_TEXT_BYTES = KEY_TEXT_W / BYTE_W;
    localparam int KSEL_W         = $clog2(KEY_TEXT_BYTES);
    localparam int KLEN_W         = 4;
    localparam int KLEN_VEC_W     = KLEN_W * KEY_REGS;
    localparam int KCNT_W         = 4;

    // Configuration port
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_TEXT_0  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_TEXT_1  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_TEXT_2  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_TEXT_3  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTHS = 3'd4;

    // Delimiters
    localparam logic [BYTE_W-1:0] CH_QMARK  = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_EQUALS = 8'h3D;
    localparam logic [BYTE_W-1:0] CH_AMP    = 8'h26;

    // Control from the parser to the key matcher
    typedef struct packed {
        logic              seg_start;
        logic              key_byte;
        logic [BYTE_W-1:0] data;
    } t_key_ctl;

endpackage

// ----- src/uqvl_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration write channel
// Register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface uqvl_cfg_if import uqvl_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/uqvl_in_if.sv -----
// ----------------------------------------------------------------------------
// URL byte channel
// One URL byte per transfer, with a last-byte mark.
// ----------------------------------------------------------------------------
interface uqvl_in_if import uqvl_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] url_byte;
    logic              last_byte;

    modport source (output valid, output url_byte, output last_byte, input ready);
    modport sink   (input valid, input url_byte, input last_byte, output ready);
endinterface

// ----- src/uqvl_out_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// One result per URL: found flag, value span and overflow flag.
// ----------------------------------------------------------------------------
interface uqvl_out_if import uqvl_pkg::*;;
    logic                valid;
    logic                ready;
    logic                found;
    logic [VSTART_W-1:0] value_start;
    logic [VLEN_W-1:0]   value_length;
    logic                too_long;

    modport source (output valid, output found, output value_start, output value_length,
                    output too_long, input ready);
    modport sink   (input valid, input found, input value_start, input value_length,
                    input too_long, output ready);
endinterface

// ----- src/url_query_value_locator_top.sv -----
// ----------------------------------------------------------------------------
// URL query value locator
// Scans a URL byte stream and reports the span of a configured key's value.
//
//   channel   dir   fields                                         transfer
//   i_cfg     in    index, data                                    valid & ready
//   i_url     in    url_byte, last_byte                            valid & ready
//   o_res     out   found, value_start, value_length, too_long     valid & ready
//
// One byte per cycle unless the input stalls; a byte is parsed while it sits
// in the input register, and the result register is loaded as a last byte is
// parsed. The parse state and key matcher update once per byte. The input
// stalls only while a result waits in the output register and the next last
// byte arrives. Reset clears valid flags, parse state, matcher and key registers.
// ----------------------------------------------------------------------------
`include "url_query_value_locator_top_macros.svh"

module url_query_value_locator_top import uqvl_pkg::*; #(
    parameter int NUM_KEYS      = 4,
    parameter int MAX_KEY_BYTES = 8,
    parameter int MAX_URL_BYTES = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    uqvl_cfg_if.sink   i_cfg,
    uqvl_in_if.sink    i_url,
    uqvl_out_if.source o_res
);

    localparam int NK    = (NUM_KEYS < KEY_REGS) ? NUM_KEYS : KEY_REGS;
    localparam int POS_W = $clog2(MAX_URL_BYTES + 1);
    localparam int CMP_W = (POS_W > VLEN_W) ? POS_W : VLEN_W;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_URL_BYTES);

    // Parse phases
    localparam logic [1:0] PH_BEFORE = 2'd0;
    localparam logic [1:0] PH_SKIPQ  = 2'd1;
    localparam logic [1:0] PH_KEY    = 2'd2;
    localparam logic [1:0] PH_VALUE  = 2'd3;

    // Key registers
    logic [KEY_REGS-1:0][KEY_TEXT_W-1:0] r_key_text;
    logic [KLEN_VEC_W-1:0]               r_key_lengths;

    // Input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;

    // Parse state
    logic [1:0]       r_phase, n_phase;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_seg, n_seg;
    logic [POS_W-1:0] r_cur, n_cur;
    logic [POS_W-1:0] r_bs, n_bs;
    logic [POS_W-1:0] r_bl, n_bl;
    logic             r_any, n_any;
    logic             r_ovf, n_ovf;

    // Result register
    logic                r_out_valid;
    logic                r_out_found;
    logic [VSTART_W-1:0] r_out_vstart;
    logic [VLEN_W-1:0]   r_out_vlen;
    logic                r_out_too_long;

    logic             w_proceed;
    logic             w_key_step;
    logic             w_key_hit;
    logic [POS_W-1:0] w_end;
    logic [POS_W-1:0] w_fin_bs;
    logic [POS_W-1:0] w_fin_bl;
    logic             w_fin_any;
    logic [CMP_W-1:0] w_bs_ext;
    logic [CMP_W-1:0] w_bl_ext;
    t_key_ctl         w_ctl_raw;
    t_key_ctl         w_ctl;

    // Configuration writes, always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_text    <= '0;
            r_key_lengths <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index) inside
                CFG_KEY_TEXT_0, CFG_KEY_TEXT_1, CFG_KEY_TEXT_2, CFG_KEY_TEXT_3: begin
                    r_key_text[i_cfg.index[$clog2(KEY_REGS)-1:0]] <= i_cfg.data;
                end
                CFG_KEY_LENGTHS: begin
                    r_key_lengths <= i_cfg.data[KLEN_VEC_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Handshake: a last byte needs a free result slot to be parsed
    assign w_proceed   = r_in_valid && (!r_in_last || !r_out_valid || o_res.ready);
    assign i_url.ready = !r_in_valid || w_proceed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_url.ready) begin
            r_in_valid <= i_url.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_url.valid && i_url.ready) begin
            r_in_byte <= i_url.url_byte;
            r_in_last <= i_url.last_byte;
        end
    end

    // Key matcher
    assign w_ctl.seg_start = w_proceed && (w_ctl_raw.seg_start || r_in_last);
    assign w_ctl.key_byte  = w_proceed && w_ctl_raw.key_byte;
    assign w_ctl.data      = r_in_byte;

    uqvl_key_match #(
        .NUM_KEYS      (NK),
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_key_match (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_key_text    (r_key_text),
        .i_key_lengths (r_key_lengths),
        .o_key_hit     (w_key_hit)
    );

    // Byte parser
    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_seg      = r_seg;
        n_cur      = r_cur;
        n_bs       = r_bs;
        n_bl       = r_bl;
        n_any      = r_any;
        n_ovf      = r_ovf;
        w_end      = r_pos;
        w_key_step = 1'b0;
        w_ctl_raw  = '0;
        if (r_pos >= POS_MAX) begin
            // past the limit: flag and stop parsing
            n_ovf = 1'b1;
            w_end = POS_MAX;
        end else begin
            n_pos = r_pos + 1'b1;
            w_end = n_pos;
            unique case (r_phase)
                PH_BEFORE: begin
                    if (r_in_byte == CH_QMARK) begin
                        n_phase = PH_SKIPQ;
                    end
                end
                PH_SKIPQ: begin
                    // matcher is already clean here, so no segment restart
                    if (r_in_byte != CH_QMARK) begin
                        n_phase    = PH_KEY;
                        w_key_step = 1'b1;
                    end
                end
                PH_KEY: begin
                    w_key_step = 1'b1;
                end
                PH_VALUE: begin
                    if (r_in_byte == CH_AMP) begin
                        if (r_seg) begin
                            n_bs  = r_cur;
                            n_bl  = (r_pos >= r_cur) ? r_pos - r_cur : '0;
                            n_any = 1'b1;
                        end
                        w_ctl_raw.seg_start = 1'b1;
                        n_seg               = 1'b0;
                        n_phase             = PH_KEY;
                    end
                end
                default: begin
                end
            endcase
            if (w_key_step) begin
                if (r_in_byte == CH_AMP) begin
                    w_ctl_raw.seg_start = 1'b1;
                    n_seg               = 1'b0;
                end else if (r_in_byte == CH_EQUALS) begin
                    n_seg   = w_key_hit;
                    n_cur   = r_pos + 1'b1;
                    n_phase = PH_VALUE;
                end else begin
                    w_ctl_raw.key_byte = 1'b1;
                end
            end
        end
    end

    // Close an open matched value at the end of the URL
    always_comb begin
        w_fin_bs  = n_bs;
        w_fin_bl  = n_bl;
        w_fin_any = n_any;
        if (n_phase == PH_VALUE && n_seg) begin
            w_fin_bs  = n_cur;
            w_fin_bl  = (w_end >= n_cur) ? w_end - n_cur : '0;
            w_fin_any = 1'b1;
        end
    end

    assign w_bs_ext = CMP_W'(w_fin_bs);
    assign w_bl_ext = CMP_W'(w_fin_bl);

    // Parse state registers, cleared after each URL
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_proceed && r_in_last)) begin
            r_phase <= PH_BEFORE;
            r_pos   <= '0;
            r_seg   <= 1'b0;
            r_cur   <= '0;
            r_bs    <= '0;
            r_bl    <= '0;
            r_any   <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (w_proceed) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_seg   <= n_seg;
            r_cur   <= n_cur;
            r_bs    <= n_bs;
            r_bl    <= n_bl;
            r_any   <= n_any;
            r_ovf   <= n_ovf;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_proceed && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_proceed && r_in_last) begin
            r_out_found    <= w_fin_any;
            r_out_too_long <= n_ovf;
            if (!w_fin_any) begin
                r_out_vstart <= '0;
                r_out_vlen   <= '0;
            end else begin
                r_out_vstart <= (w_bs_ext > CMP_W'(VSTART_MAX)) ? VSTART_MAX
                                                                : w_bs_ext[VSTART_W-1:0];
                r_out_vlen   <= w_bl_ext[VLEN_W-1:0];
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.found        = r_out_found;
    assign o_res.value_start  = r_out_vstart;
    assign o_res.value_length = r_out_vlen;
    assign o_res.too_long     = r_out_too_long;

    // Checks
    `UQVL_ASSERT_SAME(a_ovf_pos_sat, i_clk, i_rst_n, r_ovf, r_pos == POS_MAX, "overflow without saturated position")
    `UQVL_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, w_proceed && r_in_last, (r_pos == '0) && (r_phase == PH_BEFORE) && !r_any && r_out_valid, "state not cleared or result missing after last byte")
    `UQVL_ASSERT_SAME(a_notfound_zero, i_clk, i_rst_n, o_res.valid && !o_res.found, (o_res.value_start == '0) && (o_res.value_length == '0), "value span set without a match")
    `UQVL_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !w_proceed, r_in_valid && $stable(r_in_byte) && $stable(r_in_last), "stalled byte lost")

endmodule

// ----- src/uqvl_key_match.sv -----
// ----------------------------------------------------------------------------
// Key matcher
// Tracks the current segment's key bytes against all configured keys.
// ----------------------------------------------------------------------------
module uqvl_key_match import uqvl_pkg::*; #(
    parameter int NUM_KEYS      = 4,
    parameter int MAX_KEY_BYTES = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  t_key_ctl                            i_ctl,
    input  logic [KEY_REGS-1:0][KEY_TEXT_W-1:0] i_key_text,
    input  logic [KLEN_VEC_W-1:0]               i_key_lengths,
    output logic                                o_key_hit
);

    localparam logic [KCNT_W-1:0] KCNT_SAT   = KCNT_W'(MAX_KEY_BYTES + 1);
    localparam logic [KLEN_W-1:0] KLEN_MAX   = KLEN_W'(MAX_KEY_BYTES);
    localparam logic [KCNT_W-1:0] KCNT_BYTES = KCNT_W'(KEY_TEXT_BYTES);

    logic [KCNT_W-1:0]   r_kcnt;
    logic [KCNT_W-1:0]   n_kcnt;
    logic [NUM_KEYS-1:0] r_match;
    logic [NUM_KEYS-1:0] n_match;
    logic [NUM_KEYS-1:0] w_drop;
    logic [NUM_KEYS-1:0] w_hit;

    // Per-key compare of the incoming byte and completion check
    always_comb begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            w_drop[k] = (r_kcnt >= i_key_lengths[k*KLEN_W +: KLEN_W]) ||
                        (r_kcnt >= KCNT_BYTES) ||
                        (i_key_text[k][BYTE_W*r_kcnt[KSEL_W-1:0] +: BYTE_W] != i_ctl.data);
            w_hit[k]  = (i_key_lengths[k*KLEN_W +: KLEN_W] != '0) &&
                        (i_key_lengths[k*KLEN_W +: KLEN_W] <= KLEN_MAX) &&
                        r_match[k] &&
                        (r_kcnt == i_key_lengths[k*KLEN_W +: KLEN_W]);
        end
    end

    assign o_key_hit = |w_hit;

    // Next count and match mask
    always_comb begin
        n_kcnt  = r_kcnt;
        n_match = r_match;
        if (i_ctl.seg_start) begin
            n_kcnt  = '0;
            n_match = '1;
        end else if (i_ctl.key_byte) begin
            n_match = r_match & ~w_drop;
            if (r_kcnt < KCNT_SAT) begin
                n_kcnt = r_kcnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kcnt  <= '0;
            r_match <= '1;
        end else begin
            r_kcnt  <= n_kcnt;
            r_match <= n_match;
        end
    end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// URL query value locator testbench
// Streams URLs into the locator byte by byte and checks every result against
// a predictor of the query parser. Covers hand-picked corner cases, random
// URLs under several key settings and output back-pressure.
// Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
    import uqvl_pkg::*;

    localparam int URL_LIMIT     = 4096;
    localparam int KEY_MAX_BYTES = 8;
    localparam int RX_HOLD       = 300;

    typedef enum logic [1:0] {
        PH_BEFORE_Q,
        PH_SKIP_Q,
        PH_KEY_TEXT,
        PH_VALUE_TEXT
    } t_scan_phase;

    typedef struct packed {
        logic                found;
        logic [VSTART_W-1:0] value_start;
        logic [VLEN_W-1:0]   value_length;
        logic                too_long;
    } t_span_result;

    typedef logic [BYTE_W-1:0] t_byte_q[$];

    logic i_clk = 1'b0;
    logic i_rst_n;

    uqvl_cfg_if cfg_bus ();
    uqvl_in_if  url_bus ();
    uqvl_out_if res_bus ();

    url_query_value_locator_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_url   (url_bus),
        .o_res   (res_bus)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Key registers as the block should hold them
    logic [KEY_TEXT_W-1:0] key_text_cfg [KEY_REGS];
    logic [KLEN_VEC_W-1:0] key_len_cfg;

    // Parser state of the predictor
    t_scan_phase   scan_phase;
    int            scan_pos;
    int            key_bytes_seen;
    logic [3:0]    key_alive;
    logic          seg_key_hit;
    int            open_value_start;
    int            hit_start;
    int            hit_length;
    logic          hit_any;
    logic          url_overflow;

    t_span_result  expected_spans[$];
    int            fail_count = 0;

    // Idle controls for the sender and the receiver
    bit            tx_idle = 1'b1;
    bit            rx_idle = 1'b1;
    int            rx_hold_cycles = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic int key_len_of(int k);
        return int'(key_len_cfg[KLEN_W*k +: KLEN_W]);
    endfunction

    function automatic void start_key_segment();
        key_bytes_seen = 0;
        key_alive      = '1;
        seg_key_hit    = 1'b0;
    endfunction

    function automatic void clear_scan_state();
        scan_phase       = PH_BEFORE_Q;
        scan_pos         = 0;
        open_value_start = 0;
        hit_start        = 0;
        hit_length       = 0;
        hit_any          = 1'b0;
        url_overflow     = 1'b0;
        start_key_segment();
    endfunction

    function automatic void record_value_span(int span_end);
        hit_start  = open_value_start;
        hit_length = (span_end >= open_value_start) ? span_end - open_value_start : 0;
        hit_any    = 1'b1;
    endfunction

    // One byte while the key of a segment is being read
    function automatic void scan_key_byte(logic [BYTE_W-1:0] b, int p);
        int len;
        if (b == CH_AMP) begin
            start_key_segment();
        end else if (b == CH_EQUALS) begin
            seg_key_hit = 1'b0;
            for (int k = 0; k < KEY_REGS; k++) begin
                len = key_len_of(k);
                if (len >= 1 && len <= KEY_MAX_BYTES && key_alive[k] && key_bytes_seen == len)
                    seg_key_hit = 1'b1;
            end
            open_value_start = p + 1;
            scan_phase       = PH_VALUE_TEXT;
        end else begin
            for (int k = 0; k < KEY_REGS; k++) begin
                len = key_len_of(k);
                if (key_bytes_seen >= len || key_bytes_seen >= KEY_MAX_BYTES)
                    key_alive[k] = 1'b0;
                else if (key_text_cfg[k][BYTE_W*key_bytes_seen +: BYTE_W] != b)
                    key_alive[k] = 1'b0;
            end
            // count saturates one past the longest key
            if (key_bytes_seen < KEY_MAX_BYTES + 1)
                key_bytes_seen++;
        end
    endfunction

    // Advance the predictor by one accepted byte; queue a result on the last one
    function automatic void predict_url_byte(logic [BYTE_W-1:0] b, logic last);
        int           span_end;
        t_span_result r;
        if (scan_pos >= URL_LIMIT) begin
            url_overflow = 1'b1;
            span_end     = URL_LIMIT;
        end else begin
            case (scan_phase)
                PH_BEFORE_Q: begin
                    if (b == CH_QMARK)
                        scan_phase = PH_SKIP_Q;
                end
                PH_SKIP_Q: begin
                    if (b != CH_QMARK) begin
                        scan_phase = PH_KEY_TEXT;
                        start_key_segment();
                        scan_key_byte(b, scan_pos);
                    end
                end
                PH_KEY_TEXT: begin
                    scan_key_byte(b, scan_pos);
                end
                default: begin
                    if (b == CH_AMP) begin
                        if (seg_key_hit)
                            record_value_span(scan_pos);
                        start_key_segment();
                        scan_phase = PH_KEY_TEXT;
                    end
                end
            endcase
            scan_pos++;
            span_end = scan_pos;
        end

        if (last) begin
            if (scan_phase == PH_VALUE_TEXT && seg_key_hit)
                record_value_span(span_end);
            r.found        = hit_any;
            r.value_start  = !hit_any ? '0 :
                             (hit_start > int'(VSTART_MAX)) ? VSTART_MAX : VSTART_W'(hit_start);
            r.value_length = hit_any ? VLEN_W'(hit_length) : '0;
            r.too_long     = url_overflow;
            expected_spans.insert(expected_spans.size(), r);
            clear_scan_state();
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Append one byte to a URL under construction
    function automatic void add_byte(ref t_byte_q q, input logic [BYTE_W-1:0] b);
        q.insert(q.size(), b);
    endfunction

    // Random text byte; plain leaves out the delimiters
    function automatic logic [BYTE_W-1:0] pick_text_byte(bit plain);
        case ($urandom_range(plain ? 4 : 0, 11))
            0:       return CH_EQUALS;
            1:       return CH_AMP;
            2:       return CH_QMARK;
            3:       return BYTE_W'($urandom_range(0, 255));
            4, 5:    return "a";
            6, 7:    return "b";
            8:       return "x";
            9:       return "0";
            default: return "1";
        endcase
    endfunction

    function automatic logic [KEY_TEXT_W-1:0] pack_key(string s);
        logic [KEY_TEXT_W-1:0] v;
        v = '0;
        for (int i = 0; i < s.len() && i < KEY_TEXT_BYTES; i++)
            v[BYTE_W*i +: BYTE_W] = s[i];
        return v;
    endfunction

    function automatic logic [KEY_TEXT_W-1:0] rand_key_text();
        logic [KEY_TEXT_W-1:0] v;
        for (int i = 0; i < KEY_TEXT_BYTES; i++)
            v[BYTE_W*i +: BYTE_W] = ($urandom_range(0, 4) == 0) ?
                                    BYTE_W'($urandom_range(0, 255)) : pick_text_byte(1'b1);
        return v;
    endfunction

    // Mostly valid lengths, some zero and some too long
    function automatic logic [KLEN_VEC_W-1:0] rand_key_lengths();
        logic [KLEN_VEC_W-1:0] v;
        int                    r;
        for (int k = 0; k < KEY_REGS; k++) begin
            r = $urandom_range(0, 9);
            if (r < 8)
                v[KLEN_W*k +: KLEN_W] = KLEN_W'(r + 1);
            else if (r == 8)
                v[KLEN_W*k +: KLEN_W] = '0;
            else
                v[KLEN_W*k +: KLEN_W] = KLEN_W'($urandom_range(9, 15));
        end
        return v;
    endfunction

    // Random URL: mostly a query built around the configured keys, some noise
    function automatic t_byte_q make_url();
        t_byte_q u;
        int      k;
        int      len;
        int      nseg;
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 12))
                add_byte(u, ($urandom_range(0, 3) == 0) ? pick_text_byte(1'b0) :
                            BYTE_W'($urandom_range(0, 255)));
            return u;
        end
        repeat ($urandom_range(0, 3)) add_byte(u, pick_text_byte(1'b1));
        add_byte(u, CH_QMARK);
        repeat ($urandom_range(0, 2)) add_byte(u, CH_QMARK);
        nseg = $urandom_range(1, 4);
        for (int s = 0; s < nseg; s++) begin
            if (s > 0)
                add_byte(u, CH_AMP);
            k   = $urandom_range(0, KEY_REGS - 1);
            len = key_len_of(k);
            if (len == 0 || len > KEY_MAX_BYTES)
                len = $urandom_range(1, KEY_MAX_BYTES);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    for (int i = 0; i < len; i++)
                        add_byte(u, key_text_cfg[k][BYTE_W*i +: BYTE_W]);
                end
                // one byte short
                5: begin
                    for (int i = 0; i < len - 1; i++)
                        add_byte(u, key_text_cfg[k][BYTE_W*i +: BYTE_W]);
                end
                // one byte too many
                6: begin
                    for (int i = 0; i < len; i++)
                        add_byte(u, key_text_cfg[k][BYTE_W*i +: BYTE_W]);
                    add_byte(u, pick_text_byte(1'b1));
                end
                // last byte altered
                7: begin
                    for (int i = 0; i < len - 1; i++)
                        add_byte(u, key_text_cfg[k][BYTE_W*i +: BYTE_W]);
                    add_byte(u, key_text_cfg[k][BYTE_W*(len-1) +: BYTE_W] ^ 8'h01);
                end
                8: ;  // empty key
                default: begin
                    repeat ($urandom_range(1, 3)) add_byte(u, pick_text_byte(1'b1));
                end
            endcase
            if ($urandom_range(0, 7) != 0) begin
                add_byte(u, CH_EQUALS);
                repeat ($urandom_range(0, 4))
                    add_byte(u, pick_text_byte($urandom_range(0, 3) != 0));
            end
        end
        return u;
    endfunction

    // Offer one byte and wait for its transfer
    task automatic send_url_byte(input logic [BYTE_W-1:0] b, input logic last);
        int gap;
        gap = tx_idle ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            url_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        url_bus.valid     <= 1'b1;
        url_bus.url_byte  <= b;
        url_bus.last_byte <= last;
        do @(posedge i_clk); while (!url_bus.ready);
        predict_url_byte(b, last);
    endtask

    task automatic send_url(input t_byte_q u);
        for (int i = 0; i < u.size(); i++)
            send_url_byte(u[i], i == u.size() - 1);
    endtask

    task automatic send_text(input string s);
        t_byte_q u;
        for (int i = 0; i < s.len(); i++)
            add_byte(u, s[i]);
        send_url(u);
    endtask

    // Let every queued result drain and the pipeline settle
    task automatic wait_until_idle();
        url_bus.valid <= 1'b0;
        while (expected_spans.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One register transfer; valid is left high for a following write
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        do @(posedge i_clk); while (!cfg_bus.ready);
        case (idx)
            CFG_KEY_TEXT_0:  key_text_cfg[0] = data;
            CFG_KEY_TEXT_1:  key_text_cfg[1] = data;
            CFG_KEY_TEXT_2:  key_text_cfg[2] = data;
            CFG_KEY_TEXT_3:  key_text_cfg[3] = data;
            CFG_KEY_LENGTHS: key_len_cfg = data[KLEN_VEC_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_keys(input logic [KEY_TEXT_W-1:0] t0, input logic [KEY_TEXT_W-1:0] t1,
                            input logic [KEY_TEXT_W-1:0] t2, input logic [KEY_TEXT_W-1:0] t3,
                            input logic [KLEN_VEC_W-1:0] lens);
        wait_until_idle();
        write_cfg(CFG_KEY_TEXT_0, t0);
        write_cfg(CFG_KEY_TEXT_1, t1);
        write_cfg(CFG_KEY_TEXT_2, t2);
        write_cfg(CFG_KEY_TEXT_3, t3);
        write_cfg(CFG_KEY_LENGTHS, CFG_DATA_W'(lens));
        cfg_bus.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Hand-picked URLs for the parser corner cases
    task automatic test_special_cases();
        t_byte_q u;
        set_keys(pack_key("id"), pack_key("name"), pack_key("abcdefgh"), pack_key("q"),
                 {4'd1, 4'd8, 4'd4, 4'd2});
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        send_text("/p?id=42");
        send_text("nohost");                   // no query at all
        send_text("/a???id=7&x");              // repeated question marks
        send_text("?idx=1&i=2");               // keys longer and shorter than configured
        send_text("?=v&name=");                // empty key, then empty value
        send_text("?q=a=b");                   // equals sign inside the value
        send_text("?id=1&q=22");               // later match wins
        send_text("?abcdefghij=z&abcdefgh=");  // overlong key saturates the count
        send_text("?id&q");                    // segments without equals sign
        send_text("?");
        u = {8'h00, CH_QMARK, 8'hFF, CH_EQUALS, 8'h80};
        send_url(u);
        u = {8'hFF};
        send_url(u);
    endtask

    // Random URLs under a series of key settings, extremes first
    task automatic test_key_settings();
        t_byte_q u;
        int      sent;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: set_keys('0, '0, '0, '0, 16'h8888);
                1: set_keys('1, '1, '1, '1, 16'h8F08);
                2: set_keys(rand_key_text(), rand_key_text(), rand_key_text(),
                            rand_key_text(), 16'h0000);
                3: set_keys(rand_key_text(), rand_key_text(), rand_key_text(),
                            rand_key_text(), 16'hFFFF);
                default: set_keys(rand_key_text(), rand_key_text(), rand_key_text(),
                                  rand_key_text(), rand_key_lengths());
            endcase
            // some phases run one side or the other without gaps
            tx_idle = (ph % 3) != 1;
            rx_idle = (ph % 3) != 2;
            sent = 0;
            while (sent < 70) begin
                u = make_url();
                send_url(u);
                sent += u.size();
            end
        end
    endtask

    // Receiver holds off for a long stretch while URLs keep coming
    task automatic test_output_backpressure();
        set_keys(pack_key("id"), pack_key("b"), pack_key("ax"), pack_key("01"),
                 {4'd2, 4'd2, 4'd1, 4'd2});
        tx_idle        = 1'b0;
        rx_idle        = 1'b1;
        rx_hold_cycles = RX_HOLD;
        repeat (12) send_url(make_url());
    endtask

    // ------------------------------------------------------------------
    // Result receiver and checker
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    initial begin : result_checker
        int           hold;
        t_span_result want;
        res_bus.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (rx_hold_cycles > 0) begin
                hold           = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                hold = rx_idle ? $urandom_range(0, 9) : 0;
            end
            if (hold > 0) begin
                res_bus.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            res_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!res_bus.valid);
            // result transfer
            if (expected_spans.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual found=%0d start=%0d len=%0d",
                         $time, res_bus.found, res_bus.value_start, res_bus.value_length);
                fail_count++;
            end else begin
                want = expected_spans.pop_front();
                check_field("found", want.found, res_bus.found);
                check_field("value_start", want.value_start, res_bus.value_start);
                check_field("value_length", want.value_length, res_bus.value_length);
                check_field("too_long", want.too_long, res_bus.too_long);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence of tests
    // ------------------------------------------------------------------
    initial begin : stimulus
        i_rst_n           <= 1'b0;
        url_bus.valid     <= 1'b0;
        url_bus.url_byte  <= '0;
        url_bus.last_byte <= 1'b0;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.index     <= CFG_KEY_TEXT_0;
        cfg_bus.data      <= '0;
        for (int k = 0; k < KEY_REGS; k++)
            key_text_cfg[k] = '0;
        key_len_cfg = '0;
        clear_scan_state();

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_special_cases();
        test_key_settings();
        test_output_backpressure();

        wait_until_idle();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && expected_spans.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
